// ===== src/fir_or_notch_sample_filter_defines.svh =====
// Assertion macros used by the filter top level.
`ifndef FIR_OR_NOTCH_SAMPLE_FILTER_DEFINES_SVH
`define FIR_OR_NOTCH_SAMPLE_FILTER_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define FNF_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define FNF_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// ===== src/fnf_pkg.sv =====
// Package with shared types and constants of the filter.
package fnf_pkg;
    localparam logic [1:0] FUNC_FILTER = 2'd0;
    localparam logic [1:0] FUNC_COEF = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] MODE_FIR = 2'd0;
    localparam logic [1:0] MODE_NOTCH = 2'd1;
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;
    localparam logic [1:0] REG_TAP_ORDER = 2'd2;
    localparam logic [1:0] REG_NOTCH_COS = 2'd3;
    localparam int POLE_R = 32440;
    localparam int POLE_R2 = 32115;
    localparam int ACC_WIDTH = 64;

    typedef struct packed {
        logic clear;
    } mac_ctrl_t;
endpackage

// ===== src/fnf_mac.sv =====
// Shared multiply-accumulate unit with one registered product stage.
module fnf_mac
    import fnf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  mac_ctrl_t                   ctrl,
    input  logic                        op_valid,
    input  logic signed [17:0]          op_a,
    input  logic signed [33:0]          op_b,
    output logic signed [ACC_WIDTH-1:0] acc
);
    logic signed [51:0]          prod_full;
    logic signed [ACC_WIDTH-1:0] prod_reg;
    logic                        prod_valid_reg;
    logic signed [ACC_WIDTH-1:0] acc_reg;

    assign prod_full = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            prod_reg <= '0;
            acc_reg <= '0;
        end
        else
        begin
            prod_valid_reg <= op_valid;
            prod_reg <= ACC_WIDTH'(prod_full);
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    assign acc = acc_reg;
endmodule

// ===== src/fir_or_notch_sample_filter.sv =====
// Top level of the FIR or notch sample filter with sequencer and memories.
// A filtered sample first moves the whole input history one place through the
// single memory port, each entry passing the shift read and shift write states;
// then, in FIR mode, the single multiply-accumulate unit walks the coefficient
// and history memories one tap a cycle; notch mode feeds it the notch terms and
// the zero-output modes skip it. A disabled sample is passed through unchanged
// via the hold state. A coefficient write or an unused code gives no result.
// After reset and after a clear transaction the input history memory is swept
// to zero, during which no transaction is accepted. Results wait in an output
// register, so a new transaction is taken while the previous result is still
// pending; a finished result waits in the hold state until the slot is free.
`include "fir_or_notch_sample_filter_defines.svh"
module fir_or_notch_sample_filter
    import fnf_pkg::*;
#(
    parameter int MAX_TAPS = 256,
    parameter int SAMPLE_WIDTH = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0: func[1:0], sample_in, coef_index[7:0], coef_value[15:0].
    input  logic [((2+SAMPLE_WIDTH+24+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0: sample_out.
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
    localparam int AW = $clog2(MAX_TAPS);
    localparam int CW = AW + 1;
    localparam int SW = SAMPLE_WIDTH;
    localparam int OW = ((SAMPLE_WIDTH+7)/8)*8;

    typedef enum logic [3:0] {
        ST_SWEEP, ST_IDLE, ST_SHIFT_RD, ST_SHIFT_WR, ST_FIR_RD, ST_DRAIN1, ST_DRAIN2,
        ST_NOTCH, ST_FINISH, ST_HOLD
    } state_t;

    state_t state_reg;
    logic enable_reg;
    logic [1:0] mode_reg;
    logic [7:0] tap_order_reg;
    logic signed [15:0] notch_cos_reg;

    logic [SW-1:0] hist_mem [MAX_TAPS];
    logic [15:0] coef_mem [MAX_TAPS];
    logic [SW-1:0] hist_rd_reg;
    logic [15:0] coef_rd_reg;
    logic signed [SW-1:0] y0_reg, y1_reg, x_reg, carry_reg;
    logic signed [SW-1:0] x1_reg, x2_reg;
    logic [CW-1:0] cnt_reg, taps_reg;
    logic [2:0] step_reg;
    logic [SW-1:0] out_reg;
    logic out_valid_reg;
    logic rd_valid_reg;
    logic pass_reg;

    logic [1:0] in_func;
    logic signed [SW-1:0] in_sample;
    logic [7:0] in_cidx;
    logic [15:0] in_cval;
    logic accept;
    mac_ctrl_t mac_ctrl;
    logic op_valid;
    logic signed [17:0] op_a;
    logic signed [33:0] op_b;
    logic signed [ACC_WIDTH-1:0] acc;
    logic signed [ACC_WIDTH-1:0] rnd;
    logic signed [SW-1:0] sat;
    logic signed [33:0] k_full;

    assign in_func = s_axis_tdata[1:0];
    assign in_sample = s_axis_tdata[SW+1:2];
    assign in_cidx = s_axis_tdata[SW+9:SW+2];
    assign in_cval = s_axis_tdata[SW+25:SW+10];
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = OW'(out_reg);

    assign k_full = (34'(2 * POLE_R) * 34'(notch_cos_reg) + 34'sd16384) >>> 15;

    always_comb
    begin
        rnd = (acc + ACC_WIDTH'(16384)) >>> 15;
        if (rnd > ACC_WIDTH'((64'sd1 <<< (SW-1)) - 1))
        begin
            sat = {1'b0, {(SW-1){1'b1}}};
        end
        else if (rnd < -(64'sd1 <<< (SW-1)))
        begin
            sat = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            sat = rnd[SW-1:0];
        end
    end

    always_comb
    begin
        mac_ctrl = '0;
        op_valid = 1'b0;
        op_a = '0;
        op_b = '0;
        if (state_reg == ST_FIR_RD && rd_valid_reg)
        begin
            op_valid = 1'b1;
            op_a = 18'(signed'(coef_rd_reg));
            op_b = 34'(signed'(hist_rd_reg));
        end
        else if (state_reg == ST_NOTCH)
        begin
            op_valid = 1'b1;
            unique case (step_reg)
                3'd0:
                begin
                    op_a = 18'sd32768;
                    op_b = 34'(x_reg);
                end
                3'd1:
                begin
                    op_a = 18'sd32768;
                    op_b = 34'(x2_reg);
                end
                3'd2:
                begin
                    op_a = -(18'(notch_cos_reg) <<< 1);
                    op_b = 34'(x1_reg);
                end
                3'd3:
                begin
                    op_a = 18'(k_full);
                    op_b = 34'(y0_reg);
                end
                default:
                begin
                    op_a = -18'sd32115;
                    op_b = 34'(y1_reg);
                end
            endcase
        end
        if (state_reg == ST_SHIFT_RD)
        begin
            mac_ctrl.clear = 1'b1;
        end
    end

    fnf_mac u_mac (
        .clk(clk), .rst_n(rst_n), .ctrl(mac_ctrl), .op_valid(op_valid),
        .op_a(op_a), .op_b(op_b), .acc(acc)
    );

    // Sweep, history shift from oldest entry down with the sample, coef writes, reads.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP)
        begin
            hist_mem[cnt_reg[AW-1:0]] <= '0;
        end
        else if (state_reg == ST_SHIFT_WR && step_reg == 3'd2)
        begin
            hist_mem[cnt_reg[AW-1:0]] <= hist_rd_reg;
        end
        else if (state_reg == ST_SHIFT_WR && step_reg == 3'd0)
        begin
            hist_mem[cnt_reg[AW-1:0]] <= carry_reg;
        end
        if (accept && in_func == FUNC_COEF && 32'(in_cidx) < MAX_TAPS)
        begin
            coef_mem[in_cidx[AW-1:0]] <= in_cval;
        end
        hist_rd_reg <= hist_mem[cnt_reg[AW-1:0]];
        coef_rd_reg <= coef_mem[cnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            enable_reg <= 1'b1;
            mode_reg <= MODE_FIR;
            tap_order_reg <= 8'd2;
            notch_cos_reg <= '0;
            cnt_reg <= '0;
            taps_reg <= '0;
            step_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_valid_reg <= 1'b0;
            pass_reg <= 1'b0;
            out_reg <= '0;
            x_reg <= '0;
            carry_reg <= '0;
            y0_reg <= '0;
            y1_reg <= '0;
            x1_reg <= '0;
            x2_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_TAP_ORDER: tap_order_reg <= cfg_data[7:0];
                    REG_NOTCH_COS: notch_cos_reg <= cfg_data;
                endcase
            end
            if (out_valid_reg && m_axis_tready && state_reg != ST_HOLD)
            begin
                out_valid_reg <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_SWEEP:
                begin
                    if (cnt_reg == CW'(MAX_TAPS - 1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_func == FUNC_CLEAR)
                        begin
                            y0_reg <= '0;
                            y1_reg <= '0;
                            x1_reg <= '0;
                            x2_reg <= '0;
                            cnt_reg <= '0;
                            state_reg <= ST_SWEEP;
                        end
                        else if (in_func == FUNC_FILTER)
                        begin
                            x_reg <= in_sample;
                            if (!enable_reg)
                            begin
                                pass_reg <= 1'b1;
                                state_reg <= ST_HOLD;
                            end
                            else
                            begin
                                pass_reg <= 1'b0;
                                cnt_reg <= CW'(MAX_TAPS - 1);
                                state_reg <= ST_SHIFT_RD;
                            end
                        end
                    end
                end
                ST_SHIFT_RD:
                begin
                    if (cnt_reg == '0)
                    begin
                        carry_reg <= x_reg;
                        state_reg <= ST_SHIFT_WR;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        state_reg <= ST_SHIFT_WR;
                        step_reg <= 3'd1;
                    end
                end
                ST_SHIFT_WR:
                begin
                    // Read of entry cnt-1 is registered; write it to cnt next.
                    if (step_reg == 3'd1)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        step_reg <= 3'd2;
                    end
                    else if (cnt_reg == '0)
                    begin
                        step_reg <= '0;
                        cnt_reg <= '0;
                        if (mode_reg == MODE_FIR)
                        begin
                            taps_reg <= (32'(tap_order_reg) + 1 > MAX_TAPS) ?
                                CW'(MAX_TAPS) : CW'(32'(tap_order_reg) + 1);
                            state_reg <= ST_FIR_RD;
                        end
                        else if (mode_reg == MODE_NOTCH)
                        begin
                            state_reg <= ST_NOTCH;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 1'b1;
                        step_reg <= '0;
                        state_reg <= ST_SHIFT_RD;
                    end
                end
                ST_FIR_RD:
                begin
                    if (cnt_reg < taps_reg)
                    begin
                        rd_valid_reg <= 1'b1;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= ST_DRAIN1;
                    end
                end
                ST_NOTCH:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 3'd4)
                    begin
                        state_reg <= ST_DRAIN1;
                    end
                end
                ST_DRAIN1: state_reg <= ST_DRAIN2;
                ST_DRAIN2: state_reg <= ST_FINISH;
                ST_FINISH:
                begin
                    state_reg <= ST_HOLD;
                end
                default:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                        if (pass_reg)
                        begin
                            out_reg <= x_reg;
                        end
                        else
                        begin
                            out_reg <= (mode_reg == MODE_FIR || mode_reg == MODE_NOTCH) ?
                                sat : '0;
                            y1_reg <= y0_reg;
                            y0_reg <= (mode_reg == MODE_FIR || mode_reg == MODE_NOTCH) ?
                                sat : '0;
                            x2_reg <= x1_reg;
                            x1_reg <= x_reg;
                        end
                    end
                end
            endcase
        end
    end

    `FNF_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != ST_IDLE, !s_axis_tready,
        "input accepted while busy")
    `FNF_ASSERT_NEXT(a_sweep_exit, clk, rst_n,
        state_reg == ST_SWEEP && cnt_reg == CW'(MAX_TAPS - 1), state_reg == ST_IDLE,
        "clearing pass did not finish")
    `FNF_ASSERT_IMP(a_taps_bound, clk, rst_n, state_reg == ST_FIR_RD,
        cnt_reg <= taps_reg, "tap counter overran")
endmodule

// ===== tb/tb_fir_or_notch_sample_filter.sv =====
// Self-checking testbench for the FIR or notch sample filter.
`timescale 1ns / 1ps

module tb_fir_or_notch_sample_filter;
    import fnf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [1:0] MODE_ZERO = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int TAPS = 256;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 300;
    localparam int RX_HOLD_CYCLES = 3000;

    class filter_scoreboard;
        logic [23:0] expected_q[$];
        int errors;
        bit enable;
        logic [1:0] mode;
        logic [7:0] tap_order;
        longint notch_cos;
        longint x_hist[TAPS];
        longint y_hist[2];
        longint coefs[TAPS];

        function new();
            errors = 0;
            enable = 1'b1;
            mode = MODE_FIR;
            tap_order = 8'd2;
            notch_cos = 0;
            foreach (x_hist[i]) x_hist[i] = 0;
            foreach (coefs[i]) coefs[i] = 0;
            y_hist[0] = 0;
            y_hist[1] = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] value);
            case (idx)
                REG_ENABLE: enable = value[0];
                REG_MODE: mode = value[1:0];
                REG_TAP_ORDER: tap_order = value[7:0];
                REG_NOTCH_COS: notch_cos = $signed(value);
                default: ;
            endcase
        endfunction

        function longint round_sat(longint acc);
            longint r;
            r = (acc + 16384) >>> 15;
            if (r > 64'sd8388607) r = 8388607;
            if (r < -64'sd8388608) r = -8388608;
            return r;
        endfunction

        function void note_input(logic [55:0] d);
            logic [1:0] func;
            longint x;
            longint acc;
            longint k;
            longint y;
            func = d[1:0];
            x = $signed(d[25:2]);
            if (func == FUNC_COEF) begin
                coefs[d[33:26]] = $signed(d[49:34]);
            end
            else if (func == FUNC_CLEAR) begin
                foreach (x_hist[i]) x_hist[i] = 0;
                y_hist[0] = 0;
                y_hist[1] = 0;
            end
            else if (func == FUNC_FILTER) begin
                if (!enable) begin
                    expected_q.push_back(d[25:2]);
                end
                else begin
                    for (int i = TAPS - 1; i > 0; i--) x_hist[i] = x_hist[i-1];
                    x_hist[0] = x;
                    if (mode == MODE_FIR) begin
                        acc = 0;
                        for (int i = 0; i <= tap_order; i++) acc += coefs[i] * x_hist[i];
                        y = round_sat(acc);
                    end
                    else if (mode == MODE_NOTCH) begin
                        k = (2 * longint'(POLE_R) * notch_cos + 16384) >>> 15;
                        acc = 32768 * (x_hist[0] + x_hist[2]) - 2 * notch_cos * x_hist[1]
                            + k * y_hist[0] - longint'(POLE_R2) * y_hist[1];
                        y = round_sat(acc);
                    end
                    else begin
                        y = 0;
                    end
                    y_hist[1] = y_hist[0];
                    y_hist[0] = y;
                    expected_q.push_back(y[23:0]);
                end
            end
        endfunction

        function void check_result(logic [23:0] actual);
            logic [23:0] want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected sample_out %0d", $time, $signed(actual));
                errors++;
            end
            else begin
                want = expected_q.pop_front();
                if (actual !== want) begin
                    $display("%0t: sample_out expected %0d actual %0d", $time,
                             $signed(want), $signed(actual));
                    errors++;
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    filter_scoreboard sb = new();
    int tx_idle_pct = 33;
    int rx_idle_pct = 57;
    logic rx_hold_request = 1'b0;
    int rx_hold_count = 0;
    int cycle_count = 0;

    fir_or_notch_sample_filter i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata);
        end
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (rx_hold_request && rx_hold_count < RX_HOLD_CYCLES)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [55:0] pack_item(logic [1:0] func, logic [23:0] sample,
                                              logic [7:0] idx, logic [15:0] coef);
        return {6'd0, coef, idx, sample, func};
    endfunction

    task automatic send_item(logic [55:0] d);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_input(d);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_regs(logic en, logic [1:0] md, logic [7:0] order, logic [15:0] cosv);
        logic [15:0] vals[4];
        vals[REG_ENABLE] = {15'd0, en};
        vals[REG_MODE] = {14'd0, md};
        vals[REG_TAP_ORDER] = {8'd0, order};
        vals[REG_NOTCH_COS] = cosv;
        wait_idle();
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= vals[i];
            @(posedge clk);
            sb.set_reg(i[1:0], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom_range(0, 2000));
            3: return 24'(-$urandom_range(0, 2000));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 4000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_items(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_item(pack_item(FUNC_FILTER, rand_sample(), 8'($urandom),
                                    16'($urandom)));
            else if (pick < 90)
                send_item(pack_item(FUNC_COEF, 24'($urandom), 8'($urandom), rand_coef()));
            else if (pick < 95)
                send_item(pack_item(FUNC_CLEAR, 24'($urandom), 8'($urandom),
                                    16'($urandom)));
            else
                send_item(pack_item(FUNC_UNUSED, 24'($urandom), 8'($urandom),
                                    16'($urandom)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every tap gets a coefficient before any FIR sum can read it.
        for (int i = 0; i < TAPS; i++)
        begin
            send_item(pack_item(FUNC_COEF, '0, i[7:0],
                                (i == 0) ? 16'h7FFF : (i == 1) ? 16'h8000 : rand_coef()));
        end

        send_item(pack_item(FUNC_FILTER, 24'h7FFFFF, 8'hFF, 16'hFFFF));
        send_item(pack_item(FUNC_FILTER, 24'h800000, 8'h00, 16'h0000));
        send_item(pack_item(FUNC_FILTER, 24'h000000, 8'h00, 16'h0000));
        send_item(pack_item(FUNC_FILTER, 24'hFFFFFF, 8'h00, 16'h0000));
        send_item(pack_item(FUNC_UNUSED, 24'h7FFFFF, 8'hFF, 16'hFFFF));
        send_item(pack_item(FUNC_COEF, 24'hFFFFFF, 8'hFF, 16'h7FFF));
        send_item(pack_item(FUNC_COEF, 24'h000000, 8'd2, 16'h7FFF));
        send_item(pack_item(FUNC_FILTER, 24'h7FFFFF, 8'h00, 16'h0000));
        send_item(pack_item(FUNC_FILTER, 24'h7FFFFF, 8'h00, 16'h0000));
        send_item(pack_item(FUNC_CLEAR, 24'hFFFFFF, 8'hFF, 16'hFFFF));
        send_item(pack_item(FUNC_FILTER, 24'h123456, 8'h00, 16'h0000));

        for (int ph = 0; ph < 10; ph++)
        begin
            if (ph == 3)
            begin
                tx_idle_pct = 57;
                rx_idle_pct = 33;
            end
            if (ph == 7)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (ph)
                0: write_regs(1'b1, MODE_FIR, 8'd0, 16'h0000);
                1: write_regs(1'b1, MODE_FIR, 8'd255, 16'h0000);
                2: write_regs(1'b1, MODE_FIR, 8'($urandom_range(1, 20)), 16'($urandom));
                3: write_regs(1'b1, MODE_NOTCH, 8'($urandom), 16'h8000);
                4: write_regs(1'b1, MODE_NOTCH, 8'($urandom), 16'h7FFF);
                5: write_regs(1'b1, MODE_NOTCH, 8'($urandom), 16'($urandom));
                6: write_regs(1'b1, MODE_ZERO, 8'($urandom), 16'($urandom));
                7: write_regs(1'b1, MODE_SPARE, 8'($urandom), 16'($urandom));
                8: write_regs(1'b0, MODE_FIR, 8'($urandom), 16'($urandom));
                default: write_regs(1'b1, MODE_FIR, 8'($urandom_range(0, 12)),
                                    16'($urandom));
            endcase
            if (ph == 5)
            begin
                rx_hold_request = 1'b1;
            end
            random_items((ph == 1) ? 20 : 25);
        end

        wait_idle();
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+src
src/fnf_pkg.sv
src/fnf_mac.sv
src/fir_or_notch_sample_filter.sv
tb/tb_fir_or_notch_sample_filter.sv
